// ===== rtl/spsob_pkg.sv =====
// Package: payload structs, constants and divide helpers for the subtitle blend unit.
`default_nettype none
package spsob_pkg;

  localparam int unsigned MaxCanvasDim = 4096;
  localparam int unsigned DimW = 13;
  localparam int unsigned NumW = 17;
  localparam int unsigned QuoW = 10;

  localparam logic [0:0] CfgIdxWidth  = 1'b0;
  localparam logic [0:0] CfgIdxHeight = 1'b1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         coverage;
    logic [31:0]        source_color;
    logic [31:0]        dest_pixel;
  } req_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] pixel_index;
    logic [31:0] new_pixel;
  } res_t;

  // Per-channel work carried along the divider row.
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  // Divide a value of at most 255*255 by 255 exactly.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spsob_div_cell.sv =====
// Divider cell: one restoring quotient bit for three color lanes, then hand on.
`default_nettype none
module spsob_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      vld_i,
  input  wire logic [7:0]                oa_i,
  input  wire spsob_pkg::lane_t [2:0]    lane_i,
  input  wire logic [31:0]               side_i,
  input  wire logic                      we_i,
  input  wire logic [23:0]               idx_i,
  output logic                           vld_o,
  output logic [7:0]                     oa_o,
  output spsob_pkg::lane_t [2:0]         lane_o,
  output logic [31:0]                    side_o,
  output logic                           we_o,
  output logic [23:0]                    idx_o
);

  spsob_pkg::lane_t [2:0] lane_d, lane_q;
  logic [7:0]  oa_q;
  logic [31:0] side_q;
  logic        we_q, vld_q;
  logic [23:0] idx_q;

  // Try subtracting the shifted divisor from each lane remainder.
  always_comb begin
    logic [spsob_pkg::NumW+spsob_pkg::QuoW-1:0] dsh;
    dsh = {{(spsob_pkg::NumW+spsob_pkg::QuoW-8){1'b0}}, oa_i} << Bit;
    for (int l = 0; l < 3; l++) begin
      lane_d[l] = lane_i[l];
      if ({{spsob_pkg::QuoW{1'b0}}, lane_i[l].rem} >= dsh) begin
        lane_d[l].rem = lane_i[l].rem - dsh[spsob_pkg::NumW-1:0];
        lane_d[l].quo[Bit] = 1'b1;
      end
    end
  end

  // Advance payload every cycle.
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    oa_q   <= oa_i;
    side_q <= side_i;
    we_q   <= we_i;
    idx_q  <= idx_i;
  end

  // Advance the request strobe; drop it at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_i;
  end

  assign vld_o  = vld_q;
  assign oa_o   = oa_q;
  assign lane_o = lane_q;
  assign side_o = side_q;
  assign we_o   = we_q;
  assign idx_o  = idx_q;

endmodule
`default_nettype wire

// ===== rtl/subtitle_pixel_src_over_blend_unit.sv =====
// Top level: clip, alpha and numerator stages feeding a row of divider cells.
//
// Usage: raise start with req_i for one cycle; busy is always low, so a
// request is taken on every cycle start is high. Each request yields exactly
// one result on res_o, marked by done_o for one cycle; the receiver cannot
// stall it. Throughput is one request per clock. A row of ten divider cells,
// one quotient bit each, divides the three color numerators by the result
// alpha; three stages in front compute clipping, the effective alpha, the
// destination term and the pixel index.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is canvas width, index 1 canvas height, other indexes are ignored.
// cfg_ready_o is always high. Reset clears both registers to zero (which
// clips every pixel) and drops all in-flight strobes.
`default_nettype none
module subtitle_pixel_src_over_blend_unit #(
  parameter int unsigned MaxCanvasDim = spsob_pkg::MaxCanvasDim
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire spsob_pkg::req_t   req_i,
  output logic                   done_o,
  output spsob_pkg::res_t        res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [12:0]       cfg_data_i
);

  localparam int unsigned QuoW = spsob_pkg::QuoW;

  logic [12:0] wid_q, hgt_q;
  logic [2:0]  vld_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= '0;
      hgt_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == spsob_pkg::CfgIdxWidth) wid_q <= cfg_data_i;
      else                                      hgt_q <= cfg_data_i;
    end
  end

  logic [12:0] w_eff, h_eff;
  assign w_eff = ({2'b00, wid_q} > 15'(MaxCanvasDim)) ? 13'(MaxCanvasDim) : wid_q;
  assign h_eff = ({2'b00, hgt_q} > 15'(MaxCanvasDim)) ? 13'(MaxCanvasDim) : hgt_q;

  // Stage 1: clip, cov*(255-inv).
  logic        on1_q;
  logic [15:0] cf1_q;
  logic [15:0] px1_q, py1_q;
  logic [31:0] col1_q, dst1_q;
  logic [12:0] w1_q;
  logic        on1_d;
  assign on1_d = !req_i.pos_x[15] && !req_i.pos_y[15] &&
                 (req_i.pos_x < $signed({3'b0, w_eff})) &&
                 (req_i.pos_y < $signed({3'b0, h_eff})) && (req_i.coverage != 8'd0);
  always_ff @(posedge clk_i) begin
    on1_q  <= on1_d;
    cf1_q  <= req_i.coverage * (8'd255 - req_i.source_color[7:0]);
    px1_q  <= req_i.pos_x;
    py1_q  <= req_i.pos_y;
    col1_q <= req_i.source_color;
    dst1_q <= req_i.dest_pixel;
    w1_q   <= w_eff;
  end

  // Stage 2: fa, da*ia, index.
  logic [7:0]  fa2_q;
  logic [15:0] dai2_q;
  logic        we2_q;
  logic [23:0] idx2_q;
  logic [31:0] col2_q, dst2_q;
  logic [7:0]  fa1;
  assign fa1 = spsob_pkg::div255(cf1_q);
  always_ff @(posedge clk_i) begin
    fa2_q  <= fa1;
    dai2_q <= dst1_q[31:24] * (8'd255 - fa1);
    we2_q  <= on1_q && (fa1 != 8'd0);
    idx2_q <= {8'd0, py1_q} * {11'd0, w1_q} + {8'd0, px1_q};
    col2_q <= col1_q;
    dst2_q <= dst1_q;
  end

  // src*fa and dst*da*ia/255 per channel; the latter by reciprocal, then one fix-up step.
  logic [15:0] scterm [3];
  logic [16:0] dcterm [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [23:0] p;
      logic [47:0] m;
      scterm[l] = col2_q[31-8*l -: 8] * fa2_q;
      p = dst2_q[23-8*l -: 8] * dai2_q;
      m = p * 48'd65793;
      dcterm[l] = m[40:24];
      if ((25'(dcterm[l]) + 25'd1) * 25'd255 <= 25'(p)) dcterm[l] = dcterm[l] + 17'd1;
    end
  end

  // Stage 3: result alpha and channel numerators.
  logic [7:0] dai255;
  assign dai255 = spsob_pkg::div255(dai2_q);
  logic [7:0] oa3_q;
  spsob_pkg::lane_t [2:0] ln3_q;
  logic [31:0] dst3_q;
  logic        we3_q;
  logic [23:0] idx3_q;
  always_ff @(posedge clk_i) begin
    oa3_q <= fa2_q + dai255;
    for (int l = 0; l < 3; l++) begin
      ln3_q[l].rem <= {1'b0, scterm[l]} + dcterm[l];
      ln3_q[l].quo <= '0;
    end
    dst3_q <= dst2_q;
    we3_q  <= we2_q;
    idx3_q <= idx2_q;
  end

  // Divider row.
  logic                   cv [QuoW+1];
  logic [7:0]             coa [QuoW+1];
  spsob_pkg::lane_t [2:0] cln [QuoW+1];
  logic [31:0]            csd [QuoW+1];
  logic                   cwe [QuoW+1];
  logic [23:0]            cix [QuoW+1];

  // Track request strobes through the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[1:0], start};
  end

  assign cv[0]  = vld_q[2];
  assign coa[0] = oa3_q;
  assign cln[0] = ln3_q;
  assign csd[0] = dst3_q;
  assign cwe[0] = we3_q;
  assign cix[0] = idx3_q;

  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    spsob_div_cell #(.Bit(QuoW-1-g)) u_cell (
      .clk_i  (clk_i),  .rst_ni (rst_ni),
      .vld_i  (cv[g]),  .oa_i (coa[g]), .lane_i (cln[g]), .side_i (csd[g]),
      .we_i   (cwe[g]), .idx_i (cix[g]),
      .vld_o  (cv[g+1]), .oa_o (coa[g+1]), .lane_o (cln[g+1]), .side_o (csd[g+1]),
      .we_o   (cwe[g+1]), .idx_o (cix[g+1])
    );
  end

  // Drive result.
  assign done_o = cv[QuoW];
  always_comb begin
    res_o.write_enable = cwe[QuoW];
    res_o.pixel_index  = cwe[QuoW] ? cix[QuoW] : 24'd0;
    res_o.new_pixel    = cwe[QuoW] ?
      {coa[QuoW], cln[QuoW][0].quo[7:0], cln[QuoW][1].quo[7:0], cln[QuoW][2].quo[7:0]} :
      csd[QuoW];
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[2], QuoW)) else $error("strobe without request");

endmodule
`default_nettype wire

// ===== verif/subtitle_pixel_src_over_blend_unit_tb.sv =====
// Testbench: drives pixel requests and canvas settings, checks blended pixels against a predictor.
`default_nettype none
module subtitle_pixel_src_over_blend_unit_tb;

  localparam int unsigned Latency  = 13;
  localparam int unsigned Watchdog = 2000;
  localparam int unsigned NumRand  = 1050;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  spsob_pkg::req_t   req_i;
  logic              done_o;
  spsob_pkg::res_t   res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [12:0]       cfg_data_i;

  subtitle_pixel_src_over_blend_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Canvas size as the predictor sees it.
  logic [12:0] model_width;
  logic [12:0] model_height;

  spsob_pkg::res_t pending_pixels[$];
  bit      failed;
  int      idle_cycles;

  // Directed row: request plus an optional hand-written expected result.
  typedef struct {
    spsob_pkg::req_t req;
    bit              has_golden;
    spsob_pkg::res_t golden;
  } vector_t;

  function automatic logic [7:0] mix_color(input int unsigned src, input int unsigned dst,
                                           input int unsigned da, input int unsigned fa,
                                           input int unsigned ia, input int unsigned oa);
    int unsigned num;
    num = src * fa + dst * da * ia / 255;
    return 8'(num / oa);
  endfunction

  // Compute the blended pixel for one request.
  function automatic spsob_pkg::res_t blend_pixel(input spsob_pkg::req_t r);
    spsob_pkg::res_t o;
    int unsigned w, h, fa, ia, da, oa;
    logic [7:0]  cr, cg, cb;
    w = (model_width > spsob_pkg::MaxCanvasDim) ? spsob_pkg::MaxCanvasDim : model_width;
    h = (model_height > spsob_pkg::MaxCanvasDim) ? spsob_pkg::MaxCanvasDim : model_height;
    o.write_enable = 1'b0;
    o.pixel_index  = '0;
    o.new_pixel    = r.dest_pixel;
    if (r.pos_x < 0 || r.pos_y < 0) return o;
    if (int'(r.pos_x) >= int'(w) || int'(r.pos_y) >= int'(h)) return o;
    if (r.coverage == 0) return o;
    fa = r.coverage * (255 - r.source_color[7:0]) / 255;
    if (fa == 0) return o;
    ia = 255 - fa;
    da = r.dest_pixel[31:24];
    oa = (fa + da * ia / 255) & 8'hFF;
    cr = '0; cg = '0; cb = '0;
    if (oa != 0) begin
      cr = mix_color(r.source_color[31:24], r.dest_pixel[23:16], da, fa, ia, oa);
      cg = mix_color(r.source_color[23:16], r.dest_pixel[15:8], da, fa, ia, oa);
      cb = mix_color(r.source_color[15:8], r.dest_pixel[7:0], da, fa, ia, oa);
    end
    o.write_enable = 1'b1;
    o.pixel_index  = 24'(int'(r.pos_y) * w + int'(r.pos_x));
    o.new_pixel    = {8'(oa), cr, cg, cb};
    return o;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, res_o);
        failed = 1'b1;
      end else begin
        spsob_pkg::res_t want;
        want = pending_pixels.pop_front();
        if (res_o.write_enable !== want.write_enable) begin
          $display("%0t: write_enable expected %b actual %b", $realtime,
                   want.write_enable, res_o.write_enable);
          failed = 1'b1;
        end
        if (res_o.pixel_index !== want.pixel_index) begin
          $display("%0t: pixel_index expected %h actual %h", $realtime,
                   want.pixel_index, res_o.pixel_index);
          failed = 1'b1;
        end
        if (res_o.new_pixel !== want.new_pixel) begin
          $display("%0t: new_pixel expected %h actual %h", $realtime,
                   want.new_pixel, res_o.new_pixel);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: count cycles with nothing accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= Watchdog) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [12:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == spsob_pkg::CfgIdxWidth) model_width = value;
    else model_height = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop sending and wait for the pipeline to drain before touching the canvas size.
  task automatic drain;
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic set_canvas(input logic [12:0] w, input logic [12:0] h);
    drain();
    write_reg(spsob_pkg::CfgIdxWidth, w);
    write_reg(spsob_pkg::CfgIdxHeight, h);
  endtask

  // Send one request, with a random gap in front when with_gap is set; called and returns at a falling edge.
  task automatic send_request(input spsob_pkg::req_t r, input bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_pixels.push_back(blend_pixel(r));
    @(negedge clk_i);
  endtask

  function automatic spsob_pkg::req_t random_request(input int unsigned w,
                                                     input int unsigned h);
    spsob_pkg::req_t r;
    r.source_color = $urandom;
    r.dest_pixel   = $urandom;
    r.coverage     = 8'($urandom);
    case ($urandom_range(0, 9))
      0: begin r.pos_x = 16'($urandom); r.pos_y = 16'($urandom); end
      1: begin r.pos_x = 16'(w); r.pos_y = 16'($urandom_range(0, 4200)); end
      2: begin r.coverage = 0; r.pos_x = 0; r.pos_y = 0; end
      default: begin
        r.pos_x = (w == 0) ? 16'(0) : 16'($urandom_range(0, w - 1));
        r.pos_y = (h == 0) ? 16'(0) : 16'($urandom_range(0, h - 1));
      end
    endcase
    if ($urandom_range(0, 5) == 0) r.source_color[7:0] = 8'hFF - 8'($urandom_range(0, 2));
    if ($urandom_range(0, 5) == 0) r.dest_pixel[31:24] = 8'($urandom_range(0, 1)) * 8'hFF;
    return r;
  endfunction

  vector_t vectors[$];

  initial begin
    vector_t v;
    logic [12:0] dims[6][2];
    failed      = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = spsob_pkg::CfgIdxWidth;
    cfg_data_i  = '0;
    model_width  = '0;
    model_height = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // After reset the canvas is empty: everything clipped.
    v.has_golden = 1; v.req = '{0, 0, 8'hFF, 32'h11223300, 32'hA5A5A5A5};
    v.golden = '{1'b0, 24'd0, 32'hA5A5A5A5};
    vectors.push_back(v);
    foreach (vectors[i]) begin
      send_request(vectors[i].req, 1'b0);
      void'(pending_pixels.pop_back());
      pending_pixels.push_back(vectors[i].golden);
    end
    vectors.delete();

    set_canvas(13'd8191, 13'd8191);
    // Extremes: oversized canvas clamps, corners, edges, opaque over anything.
    v.has_golden = 1; v.req = '{16'sd4095, 16'sd4095, 8'hFF, 32'hFFFFFF00, 32'h00000000};
    v.golden = '{1'b1, 24'hFFFFFF, 32'hFFFFFFFF};
    vectors.push_back(v);
    v.req = '{16'sd0, 16'sd0, 8'hFF, 32'h00000000, 32'hFFFFFFFF};
    v.golden = '{1'b1, 24'd0, 32'hFF000000};
    vectors.push_back(v);
    v.req = '{16'sd4096, 16'sd0, 8'hFF, 32'h12345600, 32'h89ABCDEF};
    v.golden = '{1'b0, 24'd0, 32'h89ABCDEF};
    vectors.push_back(v);
    v.req = '{16'sd0, 16'sd4096, 8'hFF, 32'h12345600, 32'h89ABCDEF};
    v.golden = '{1'b0, 24'd0, 32'h89ABCDEF};
    vectors.push_back(v);
    v.req = '{-16'sd1, 16'sd5, 8'hFF, 32'h12345600, 32'h89ABCDEF};
    v.golden = '{1'b0, 24'd0, 32'h89ABCDEF};
    vectors.push_back(v);
    v.req = '{16'sd5, -16'sd32768, 8'hFF, 32'h12345600, 32'h89ABCDEF};
    v.golden = '{1'b0, 24'd0, 32'h89ABCDEF};
    vectors.push_back(v);
    v.req = '{16'sd32767, 16'sd1, 8'hFF, 32'h12345600, 32'h89ABCDEF};
    v.golden = '{1'b0, 24'd0, 32'h89ABCDEF};
    vectors.push_back(v);
    // Nothing to paint: zero coverage, fully transparent color, tiny alpha.
    v.req = '{16'sd3, 16'sd3, 8'h00, 32'hFFFFFF00, 32'h12345678};
    v.golden = '{1'b0, 24'd0, 32'h12345678};
    vectors.push_back(v);
    v.req = '{16'sd3, 16'sd3, 8'hFF, 32'hFFFFFFFF, 32'h12345678};
    v.golden = '{1'b0, 24'd0, 32'h12345678};
    vectors.push_back(v);
    v.req = '{16'sd3, 16'sd3, 8'h01, 32'hFFFFFF01, 32'h12345678};
    v.golden = '{1'b0, 24'd0, 32'h12345678};
    vectors.push_back(v);
    // Predictor rows: partial alpha, channel wrap, transparent destination.
    v.has_golden = 0;
    v.req = '{16'sd7, 16'sd9, 8'h80, 32'hFF00807F, 32'hFF102030}; vectors.push_back(v);
    v.req = '{16'sd1, 16'sd2, 8'h01, 32'hFFFFFFFE, 32'hFFFFFFFF}; vectors.push_back(v);
    v.req = '{16'sd100, 16'sd1, 8'h40, 32'hFFFFFF00, 32'h01FFFFFF}; vectors.push_back(v);
    v.req = '{16'sd2, 16'sd2, 8'hFE, 32'h55AA5580, 32'h80AA55AA}; vectors.push_back(v);
    v.req = '{16'sd9, 16'sd4000, 8'h7F, 32'hAAAAAA01, 32'h7F000000}; vectors.push_back(v);
    foreach (vectors[i]) begin
      send_request(vectors[i].req, 1'b1);
      if (vectors[i].has_golden) begin
        void'(pending_pixels.pop_back());
        pending_pixels.push_back(vectors[i].golden);
      end
    end

    // Random phases over several canvas sizes, extremes included.
    dims = '{'{13'd1, 13'd1}, '{13'd4096, 13'd4096}, '{13'd0, 13'd77},
             '{13'd640, 13'd360}, '{13'd4097, 13'd3}, '{13'd8191, 13'd0}};
    for (int p = 0; p < 6; p++) begin
      int unsigned w, h;
      set_canvas(dims[p][0], dims[p][1]);
      w = (dims[p][0] > spsob_pkg::MaxCanvasDim) ? spsob_pkg::MaxCanvasDim : dims[p][0];
      h = (dims[p][1] > spsob_pkg::MaxCanvasDim) ? spsob_pkg::MaxCanvasDim : dims[p][1];
      for (int n = 0; n < NumRand / 6; n++) begin
        // Hold off once until the pipeline is empty.
        if (p == 1 && n == 50) begin
          start <= 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        send_request(random_request(w, h), n % 100 < 70);
      end
    end

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
